// ===== sv/ectc_pkg.sv =====
// ============================================================================
// ectc_pkg: shared constants and types for epoch seconds to civil time
// Field widths, pipeline depths and the reciprocal constants that replace
// every division by a constant in the datapath.
// ============================================================================
`default_nettype none

package ectc_pkg;

   // Input port width and the number of its bits that carry the count
   localparam int EPOCH_W       = 40;
   localparam int SECONDS_WIDTH = 40;
   localparam int SECS_W        = (SECONDS_WIDTH < 32) ? 32 :
                                  (SECONDS_WIDTH > 48) ? 48 : SECONDS_WIDTH;
   // Datapath width of the sign-extended count (largest supported width)
   localparam int EXT_W         = 48;

   // Result field widths
   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int WDAY_W  = 3;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;

   // Pipeline depth: day split, then date and time of day side by side
   localparam int SPLIT_STAGES = 5;
   localparam int PATH_STAGES  = 9;
   localparam int NUM_STAGES   = SPLIT_STAGES + PATH_STAGES;

   // Biased count of 128-second units, split in two halves for the
   // long division by 675 (86400 = 128 * 675)
   localparam int U_W  = EXT_W - 6;
   localparam int UL_W = 21;
   localparam int UH_W = U_W - UL_W;
   localparam int KEY_W = 32;
   localparam int SOD_W = 17;
   localparam int ERA_W = 15;
   localparam int DOE_W = 18;
   localparam int YOE_W = 9;
   localparam int DOY_W = 9;

   localparam int DAY_DIV     = 675;
   localparam int ERA_DAYS    = 146097;
   localparam int DOE_LAST    = 146096;
   localparam int YEAR_DAYS   = 365;
   localparam int HOUR_SECS   = 3600;
   localparam int MIN_SECS    = 60;
   localparam int WEEK_DAYS   = 7;
   localparam int ERA_YEARS   = 400;
   localparam int MP_JANUARY  = 10;   // March-based month index of January
   localparam int WDAY_OFFSET = 3;    // biased day key plus this is 0 on Sunday

   // Bias of 675 * (days from 0000-03-01 to the epoch + 2^14 eras): the
   // quotient by 675 is then the day key, never negative
   localparam logic [U_W-1:0] DAY_BIAS =
      U_W'(64'd675 * (64'd719468 + 64'd146097 * 64'd16384));

   // Reciprocals ceil(2^(N+L)/d), exact for every N-bit numerator
   localparam logic [21:0] RCP_675_HI = 22'(((64'd1 << 31) + 64'd674) / 64'd675);
   localparam logic [31:0] RCP_675_LO = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
   localparam logic [32:0] RCP_ERA    = 33'(((64'd1 << 50) + 64'd146096) / 64'd146097);
   localparam logic [17:0] RCP_HOUR   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
   localparam logic [12:0] RCP_MIN    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
   localparam logic [18:0] RCP_WEEK   = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
   localparam logic [18:0] RCP_1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [18:0] RCP_36524  = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
   localparam logic [18:0] RCP_YEAR   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [9:0]  RCP_CENT   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
   localparam logic [11:0] RCP_MP     = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam logic [11:0] RCP_FIFTH  = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

   typedef logic [KEY_W-1:0] day_key_type;
   typedef logic [SOD_W-1:0] sod_type;

   typedef struct packed {
      logic [HOUR_W-1:0] hour;
      logic [MIN_W-1:0]  minute;
      logic [SEC_W-1:0]  second;
   } tod_type;

endpackage

`default_nettype wire

// ===== sv/ectc_if.sv =====
// ============================================================================
// ectc_if: timestamp and civil time channels
// Valid/ready channels for the request timestamp and the civil time result.
// ============================================================================
`default_nettype none

interface ectc_req_if import ectc_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [EPOCH_W-1:0] epoch_seconds;

   modport source (output valid, output epoch_seconds, input ready);
   modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ectc_rsp_if import ectc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [YEAR_W-1:0] year;
   logic [MONTH_W-1:0]       month;
   logic [DAY_W-1:0]         day_of_month;
   logic [WDAY_W-1:0]        weekday;
   logic [HOUR_W-1:0]        hour;
   logic [MIN_W-1:0]         minute;
   logic [SEC_W-1:0]         second;

   modport source (output valid, output year, output month, output day_of_month,
                   output weekday, output hour, output minute, output second,
                   input ready);
   modport sink   (input valid, input year, input month, input day_of_month,
                   input weekday, input hour, input minute, input second,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/epoch_seconds_to_civil_time.sv =====
// ============================================================================
// epoch_seconds_to_civil_time: Unix seconds to proleptic Gregorian time
// Converts a signed seconds count to year, month, day, weekday and time of
// day, with floor semantics for negative counts.
// ============================================================================
//
//   channel  dir  payload                                         transfer
//   -------  ---  ----------------------------------------------  -----------
//   req      in   epoch_seconds (40b signed)                      valid/ready
//   rsp      out  year, month, day_of_month, weekday, hour,       valid/ready
//                 minute, second
//
// Fourteen register stages; one item enters per cycle while nothing stalls.
// Depth is set by the chain of reciprocal multiplies: long division by 675,
// then era, year of era and month index, each multiply registered before
// the next.
// Reset clears only the stage valid bits; payload registers carry no reset.
// A stall on rsp backs up stage by stage: an empty stage still takes an item,
// so bubbles fill and req stays ready until every stage holds an item.
// ============================================================================
`default_nettype none

module epoch_seconds_to_civil_time import ectc_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   ectc_req_if.sink    req,
   ectc_rsp_if.source  rsp
);

   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] adv;

   // A stage loads when it is empty or when the stage after it loads
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   // Advance the valid bits with the data they describe
   always_comb begin
      vld_in[0] = adv[0] ? req.valid : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = adv[0];
   assign rsp.valid = vld_ff[NUM_STAGES-1];

   // Split into day key and second of day
   day_key_type day_key;
   sod_type     sod;

   ectc_day_split u_day_split (
      .clock         (clock),
      .stage_en      (adv[SPLIT_STAGES-1:0]),
      .epoch_seconds (req.epoch_seconds),
      .day_key       (day_key),
      .sod           (sod)
   );

   // Date and time of day run side by side over the same stages
   ectc_date u_date (
      .clock        (clock),
      .stage_en     (adv[NUM_STAGES-1:SPLIT_STAGES]),
      .day_key      (day_key),
      .year         (rsp.year),
      .month        (rsp.month),
      .day_of_month (rsp.day_of_month),
      .weekday      (rsp.weekday)
   );

   tod_type tod;

   ectc_tod u_tod (
      .clock    (clock),
      .stage_en (adv[NUM_STAGES-1:SPLIT_STAGES]),
      .sod      (sod),
      .tod      (tod)
   );

   assign rsp.hour   = tod.hour;
   assign rsp.minute = tod.minute;
   assign rsp.second = tod.second;

endmodule

`default_nettype wire

// ===== sv/ectc_day_split.sv =====
// ============================================================================
// ectc_day_split: seconds count to day key and second of day
// Floor division by 86400 as a shift by 7 and a two-half long division by
// 675 with reciprocal multiplies, five register stages.
// ============================================================================
`default_nettype none

module ectc_day_split import ectc_pkg::*; (
   input  wire logic                      clock,
   input  wire logic [SPLIT_STAGES-1:0]   stage_en,
   input  wire logic signed [EPOCH_W-1:0] epoch_seconds,
   output day_key_type                    day_key,
   output sod_type                        sod
);

   logic signed [EXT_W-1:0] secs_ext;

   // Keep only the used width; its top bit is the sign when it fits the port, else zero-extend
   if (SECS_W <= EPOCH_W) begin : g_narrow
      assign secs_ext = {{(EXT_W-SECS_W){epoch_seconds[SECS_W-1]}},
                         epoch_seconds[SECS_W-1:0]};
   end else begin : g_wide
      assign secs_ext = {{(EXT_W-EPOCH_W){1'b0}}, epoch_seconds};
   end

   // stage 0: bias the count of 128-second units
   logic [U_W-1:0] u0_in, u0_ff;
   logic [6:0]     lo0_in, lo0_ff;

   assign u0_in  = {secs_ext[EXT_W-1], secs_ext[EXT_W-1:7]} + DAY_BIAS;
   assign lo0_in = secs_ext[6:0];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         u0_ff  <= u0_in;
         lo0_ff <= lo0_in;
      end
   end

   // stage 1: quotient of the upper half
   logic [UH_W+21:0] hi_prod;
   logic [10:0]      qh1_in, qh1_ff;
   logic [U_W-1:0]   u1_ff;
   logic [6:0]       lo1_ff;

   assign hi_prod = (UH_W+22)'(u0_ff[U_W-1:UL_W]) * (UH_W+22)'(RCP_675_HI);
   assign qh1_in  = hi_prod[41:31];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         qh1_ff <= qh1_in;
         u1_ff  <= u0_ff;
         lo1_ff <= lo0_ff;
      end
   end

   // stage 2: remainder of the upper half joins the lower half
   logic [UH_W-1:0]    rh_full;
   logic [UL_W+9:0]    next2_in, next2_ff;
   logic [10:0]        qh2_ff;
   logic [6:0]         lo2_ff;

   assign rh_full  = u1_ff[U_W-1:UL_W] - UH_W'(qh1_ff) * UH_W'(DAY_DIV);
   assign next2_in = {rh_full[9:0], u1_ff[UL_W-1:0]};

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         next2_ff <= next2_in;
         qh2_ff   <= qh1_ff;
         lo2_ff   <= lo1_ff;
      end
   end

   // stage 3: quotient of the joined lower part
   logic [UL_W+41:0] lo_prod;
   logic [UL_W-1:0]  ql3_in, ql3_ff;
   logic [UL_W+9:0]  next3_ff;
   logic [10:0]      qh3_ff;
   logic [6:0]       lo3_ff;

   assign lo_prod = (UL_W+42)'(next2_ff) * (UL_W+42)'(RCP_675_LO);
   assign ql3_in  = lo_prod[41+UL_W-1:41];

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         ql3_ff   <= ql3_in;
         next3_ff <= next2_ff;
         qh3_ff   <= qh2_ff;
         lo3_ff   <= lo2_ff;
      end
   end

   // stage 4: day key and second of day
   logic [UL_W+9:0] rl_full;
   day_key_type     key_in, key_ff;
   sod_type         sod_in, sod_ff;

   assign rl_full = next3_ff - (UL_W+10)'(ql3_ff) * (UL_W+10)'(DAY_DIV);
   assign key_in  = {qh3_ff, ql3_ff};
   assign sod_in  = {rl_full[9:0], lo3_ff};

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         key_ff <= key_in;
         sod_ff <= sod_in;
      end
   end

   assign day_key = key_ff;
   assign sod     = sod_ff;

endmodule

`default_nettype wire

// ===== sv/ectc_date.sv =====
// ============================================================================
// ectc_date: day key to calendar date and weekday
// Era and day of era, year of era, day of year, March-based month, then the
// civil year, month and day, nine register stages.
// ============================================================================
`default_nettype none

module ectc_date import ectc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic [PATH_STAGES-1:0] stage_en,
   input  wire day_key_type            day_key,
   output logic signed [YEAR_W-1:0]    year,
   output logic [MONTH_W-1:0]          month,
   output logic [DAY_W-1:0]            day_of_month,
   output logic [WDAY_W-1:0]           weekday
);

   // stage 0: biased era
   logic [KEY_W+32:0] era_prod;
   logic [ERA_W-1:0]  era0_in, era0_ff;
   day_key_type       key0_ff;

   assign era_prod = (KEY_W+33)'(day_key) * (KEY_W+33)'(RCP_ERA);
   assign era0_in  = era_prod[50+ERA_W-1:50];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         era0_ff <= era0_in;
         key0_ff <= day_key;
      end
   end

   // stage 1: day of era; era years, wrapped to the field (bias is 0 mod 2^16)
   logic [KEY_W-1:0]  doe_full;
   logic [ERA_W+8:0]  era_years;
   logic [DOE_W-1:0]  doe1_in, doe1_ff;
   logic [YEAR_W-1:0] yb1_in, yb1_ff;

   assign doe_full  = key0_ff - KEY_W'(era0_ff) * KEY_W'(ERA_DAYS);
   assign doe1_in   = doe_full[DOE_W-1:0];
   assign era_years = (ERA_W+9)'(era0_ff) * (ERA_W+9)'(ERA_YEARS);
   assign yb1_in    = era_years[YEAR_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         doe1_ff <= doe1_in;
         yb1_ff  <= yb1_in;
      end
   end

   // stage 2: leap corrections and week quotient
   logic [DOE_W+18:0] p1460, p36524, pweek;
   logic [DOE_W-1:0]  doe_wk;
   logic [7:0]        q1460_in, q1460_ff;
   logic [2:0]        q36524_in, q36524_ff;
   logic [14:0]       w7_in, w7_ff;
   logic [DOE_W-1:0]  doe2_ff;
   logic [YEAR_W-1:0] yb2_ff;

   assign doe_wk    = doe1_ff + DOE_W'(WDAY_OFFSET);
   assign p1460     = (DOE_W+19)'(doe1_ff) * (DOE_W+19)'(RCP_1460);
   assign p36524    = (DOE_W+19)'(doe1_ff) * (DOE_W+19)'(RCP_36524);
   assign pweek     = (DOE_W+19)'(doe_wk) * (DOE_W+19)'(RCP_WEEK);
   assign q1460_in  = p1460[36:29];
   assign q36524_in = p36524[36:34];
   assign w7_in     = pweek[35:21];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         q1460_ff  <= q1460_in;
         q36524_ff <= q36524_in;
         w7_ff     <= w7_in;
         doe2_ff   <= doe1_ff;
         yb2_ff    <= yb1_ff;
      end
   end

   // stage 3: leap-adjusted day count and weekday
   logic [DOE_W-1:0]  adj3_in, adj3_ff, wd_full;
   logic [WDAY_W-1:0] wd3_in, wd3_ff;
   logic [DOE_W-1:0]  doe3_ff;
   logic [YEAR_W-1:0] yb3_ff;

   assign adj3_in = doe2_ff - DOE_W'(q1460_ff) + DOE_W'(q36524_ff)
                    - DOE_W'(doe2_ff == DOE_W'(DOE_LAST));
   assign wd_full = doe2_ff + DOE_W'(WDAY_OFFSET) - DOE_W'(w7_ff) * DOE_W'(WEEK_DAYS);
   assign wd3_in  = wd_full[WDAY_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         adj3_ff <= adj3_in;
         wd3_ff  <= wd3_in;
         doe3_ff <= doe2_ff;
         yb3_ff  <= yb2_ff;
      end
   end

   // stage 4: year of era
   logic [DOE_W+18:0] pyear;
   logic [YOE_W-1:0]  yoe4_in, yoe4_ff;
   logic [WDAY_W-1:0] wd4_ff;
   logic [DOE_W-1:0]  doe4_ff;
   logic [YEAR_W-1:0] yb4_ff;

   assign pyear   = (DOE_W+19)'(adj3_ff) * (DOE_W+19)'(RCP_YEAR);
   assign yoe4_in = pyear[27+YOE_W-1:27];

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         yoe4_ff <= yoe4_in;
         wd4_ff  <= wd3_ff;
         doe4_ff <= doe3_ff;
         yb4_ff  <= yb3_ff;
      end
   end

   // stage 5: day of year, March based
   logic [YOE_W+9:0]  pcent;
   logic [DOE_W-1:0]  ystart, doy_full;
   logic [DOY_W-1:0]  doy5_in, doy5_ff;
   logic [YOE_W-1:0]  yoe5_ff;
   logic [WDAY_W-1:0] wd5_ff;
   logic [YEAR_W-1:0] yb5_ff;

   assign pcent    = (YOE_W+10)'(yoe4_ff) * (YOE_W+10)'(RCP_CENT);
   assign ystart   = DOE_W'(yoe4_ff) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe4_ff >> 2)
                     - DOE_W'(pcent[18:16]);
   assign doy_full = doe4_ff - ystart;
   assign doy5_in  = doy_full[DOY_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         doy5_ff <= doy5_in;
         yoe5_ff <= yoe4_ff;
         wd5_ff  <= wd4_ff;
         yb5_ff  <= yb4_ff;
      end
   end

   // stage 6: March-based month index
   logic [10:0]       mp_num;
   logic [22:0]       pmp;
   logic [3:0]        mp6_in, mp6_ff;
   logic [DOY_W-1:0]  doy6_ff;
   logic [YOE_W-1:0]  yoe6_ff;
   logic [WDAY_W-1:0] wd6_ff;
   logic [YEAR_W-1:0] yb6_ff;

   assign mp_num = 11'(doy5_ff) * 11'd5 + 11'd2;
   assign pmp    = 23'(mp_num) * 23'(RCP_MP);
   assign mp6_in = pmp[22:19];

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         mp6_ff  <= mp6_in;
         doy6_ff <= doy5_ff;
         yoe6_ff <= yoe5_ff;
         wd6_ff  <= wd5_ff;
         yb6_ff  <= yb5_ff;
      end
   end

   // stage 7: first day of the month within the March-based year
   logic [10:0]       ms_num;
   logic [22:0]       pms;
   logic [DOY_W-1:0]  ms7_in, ms7_ff;
   logic [3:0]        mp7_ff;
   logic [DOY_W-1:0]  doy7_ff;
   logic [YOE_W-1:0]  yoe7_ff;
   logic [WDAY_W-1:0] wd7_ff;
   logic [YEAR_W-1:0] yb7_ff;

   assign ms_num = 11'(mp6_ff) * 11'd153 + 11'd2;
   assign pms    = 23'(ms_num) * 23'(RCP_FIFTH);
   assign ms7_in = pms[14+DOY_W-1:14];

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         ms7_ff  <= ms7_in;
         mp7_ff  <= mp6_ff;
         doy7_ff <= doy6_ff;
         yoe7_ff <= yoe6_ff;
         wd7_ff  <= wd6_ff;
         yb7_ff  <= yb6_ff;
      end
   end

   // stage 8: civil fields; January and February belong to the next year
   logic                     early_year;
   logic [DOY_W-1:0]         dom_full;
   logic signed [YEAR_W-1:0] year_in, year_ff;
   logic [MONTH_W-1:0]       month_in, month_ff;
   logic [DAY_W-1:0]         dom_in, dom_ff;
   logic [WDAY_W-1:0]        wday_ff;

   assign early_year = (mp7_ff >= 4'(MP_JANUARY));
   assign dom_full   = doy7_ff - ms7_ff + DOY_W'(1);
   assign dom_in     = dom_full[DAY_W-1:0];
   assign month_in   = early_year ? mp7_ff - 4'(MP_JANUARY - 1) : mp7_ff + 4'd3;
   assign year_in    = yb7_ff + YEAR_W'(yoe7_ff) + YEAR_W'(early_year);

   always_ff @(posedge clock) begin
      if (stage_en[8]) begin
         year_ff  <= year_in;
         month_ff <= month_in;
         dom_ff   <= dom_in;
         wday_ff  <= wd7_ff;
      end
   end

   assign year         = year_ff;
   assign month        = month_ff;
   assign day_of_month = dom_ff;
   assign weekday      = wday_ff;

endmodule

`default_nettype wire

// ===== sv/ectc_tod.sv =====
// ============================================================================
// ectc_tod: second of day to hour, minute and second
// Reciprocal divides by 3600 and 60 in four stages, then a delay line that
// keeps the fields aligned with the date path.
// ============================================================================
`default_nettype none

module ectc_tod import ectc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic [PATH_STAGES-1:0] stage_en,
   input  wire sod_type                sod,
   output tod_type                     tod
);

   localparam int DELAY = PATH_STAGES - 4;

   // stage 0: hour
   logic [SOD_W+17:0] phour;
   logic [HOUR_W-1:0] hh0_in, hh0_ff;
   sod_type           sod0_ff;

   assign phour  = (SOD_W+18)'(sod) * (SOD_W+18)'(RCP_HOUR);
   assign hh0_in = phour[29+HOUR_W-1:29];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         hh0_ff  <= hh0_in;
         sod0_ff <= sod;
      end
   end

   // stage 1: seconds within the hour
   sod_type           rs_full;
   logic [11:0]       rs1_in, rs1_ff;
   logic [HOUR_W-1:0] hh1_ff;

   assign rs_full = sod0_ff - SOD_W'(hh0_ff) * SOD_W'(HOUR_SECS);
   assign rs1_in  = rs_full[11:0];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rs1_ff <= rs1_in;
         hh1_ff <= hh0_ff;
      end
   end

   // stage 2: minute
   logic [24:0]       pmin;
   logic [MIN_W-1:0]  mi2_in, mi2_ff;
   logic [11:0]       rs2_ff;
   logic [HOUR_W-1:0] hh2_ff;

   assign pmin   = 25'(rs1_ff) * 25'(RCP_MIN);
   assign mi2_in = pmin[18+MIN_W-1:18];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         mi2_ff <= mi2_in;
         rs2_ff <= rs1_ff;
         hh2_ff <= hh1_ff;
      end
   end

   // stage 3: second
   logic [11:0] ss_full;
   tod_type     tod3_in, tod3_ff;

   assign ss_full        = rs2_ff - 12'(mi2_ff) * 12'(MIN_SECS);
   assign tod3_in.hour   = hh2_ff;
   assign tod3_in.minute = mi2_ff;
   assign tod3_in.second = ss_full[SEC_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         tod3_ff <= tod3_in;
      end
   end

   // Delay line: hold each entry until its stage advances
   tod_type tdl_ff [DELAY];

   always_ff @(posedge clock) begin
      for (int k = 0; k < DELAY; k++) begin
         if (stage_en[4+k]) begin
            tdl_ff[k] <= (k == 0) ? tod3_ff : tdl_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign tod = tdl_ff[DELAY-1];

endmodule

`default_nettype wire
